@@ hdl/trsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsi_pkg
// Shared widths, codes, state type and control structs of the sample ring
// ----------------------------------------------------------------------------
package trsi_pkg;

	localparam int RING_DEPTH = 64;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int TW         = 32;
	localparam int PW         = 32;
	localparam int LANES      = 3;
	localparam int EW         = TW + LANES * PW;
	// product of a 33-bit magnitude and a 32-bit time offset
	localparam int QW         = 65;
	localparam int CW         = $clog2(QW);

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_QUERY = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ARG   = 2'd1;
	localparam logic [1:0] ST_STATE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR,
		S_RD,
		S_RDW,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_ACC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic latch;
		logic wr;
		logic rd;
		logic rdw;
		logic scan;
		logic mul;
		logic div;
		logic acc;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic scan_interp;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/trsi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsi_ram
// Generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module trsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/trsi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsi_ctrl
// Command sequencer: decodes a beat and steps the datapath through its work
// ----------------------------------------------------------------------------
module trsi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  trsi_pkg::sts_t st,
	output trsi_pkg::cmd_t cmd
);
	import trsi_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_WRITE: state_d = S_WR;
						FN_QUERY: state_d = S_SCAN;
						FN_READ:  state_d = S_RD;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_WR:   state_d = S_FIN;
			S_RD:   state_d = S_RDW;
			S_RDW:  state_d = S_FIN;
			S_SCAN: begin
				if (st.scan_done) begin
					state_d = S_FIN;
				end else if (st.scan_interp) begin
					state_d = S_MUL;
				end
			end
			S_MUL:  state_d = S_DIV;
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC:  state_d = S_FIN;
			S_FIN: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			S_WR:   cmd.wr   = 1'b1;
			S_RD:   cmd.rd   = 1'b1;
			S_RDW:  cmd.rdw  = 1'b1;
			S_SCAN: cmd.scan = 1'b1;
			S_MUL:  cmd.mul  = 1'b1;
			S_DIV:  cmd.div  = 1'b1;
			S_ACC:  cmd.acc  = 1'b1;
			S_FIN:  cmd.fin  = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ hdl/trsi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsi_dp
// Datapath: sample ring, ring scan, multiply, serial divide, output register
// ----------------------------------------------------------------------------
module trsi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  trsi_pkg::cmd_t      cmd,
	output trsi_pkg::sts_t      st,
	input  logic [31:0]         time_stamp,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [31:0]         out_time,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z
);
	import trsi_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] DLAST = CW'(QW - 1);
	localparam logic [QW-1:0] QSAT = QW'(64'h2_0000_0000);
	localparam logic signed [35:0] RMAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] RMIN = -36'sh0_8000_0000;

	// beat registers
	logic [TW-1:0]        t_q;
	logic signed [PW-1:0] p_in_q [LANES];

	// ring control
	logic [AW-1:0]       wp_q, rp_q, iss_q, chk_q;
	logic [TW-1:0]       newest_q;
	logic [RING_DEPTH-1:0] vld_q;
	logic                rv_s1, vld_s1;

	// ram
	logic          we;
	logic [AW-1:0] raddr;
	logic [EW-1:0] wdata, rdata;
	logic [AW:0]   addr_sum;
	logic [AW-1:0] scan_addr;

	// entry just read, zero when never written
	logic [TW-1:0]        ent_t;
	logic signed [PW-1:0] ent_p [LANES];

	// bracketing entries
	logic [TW-1:0]        prev_t_q, cur_t_q;
	logic signed [PW-1:0] prev_p_q [LANES];
	logic signed [PW-1:0] cur_p_q [LANES];

	// arithmetic lanes
	logic [TW-1:0]  span_q;
	logic [CW-1:0]  dcnt_q;
	logic [QW-1:0]  dvd_q [LANES];
	logic [TW-1:0]  rem_q [LANES];
	logic           neg_q [LANES];
	logic [QW-1:0]  prod  [LANES];
	logic           neg_d [LANES];
	logic [QW-1:0]  dvd_d [LANES];
	logic [TW-1:0]  rem_d [LANES];
	logic signed [PW-1:0] sat_p [LANES];

	// result before the output register
	logic [1:0]           res_st_q;
	logic [TW-1:0]        res_t_q;
	logic signed [PW-1:0] res_p_q [LANES];
	logic                 out_valid_q;

	// scan decisions
	logic eval, s_err, s_ge, s_hit, s_exact, s_same;
	logic wr_ok;

	// ring address generation
	always_comb begin
		addr_sum  = {1'b0, wp_q} + {1'b0, iss_q};
		scan_addr = (addr_sum >= (AW+1)'(RING_DEPTH)) ?
			AW'(addr_sum - (AW+1)'(RING_DEPTH)) : addr_sum[AW-1:0];
		raddr = cmd.rd ? rp_q : scan_addr;
		wr_ok = t_q > newest_q;
		we    = cmd.wr && wr_ok;
		wdata = {p_in_q[2], p_in_q[1], p_in_q[0], t_q};
	end

	trsi_ram #(
		.WIDTH(EW),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// masked entry decode
	always_comb begin
		ent_t = vld_s1 ? rdata[TW-1:0] : '0;
		for (int i = 0; i < LANES; i++) begin
			ent_p[i] = vld_s1 ? rdata[TW + i*PW +: PW] : '0;
		end
	end

	// scan compare on the entry in hand
	always_comb begin
		eval    = cmd.scan && rv_s1;
		s_err   = (chk_q == '0) && ((t_q == '0) || (t_q < ent_t));
		s_ge    = ent_t >= t_q;
		s_hit   = !s_err && (s_ge || (chk_q == LAST));
		s_exact = s_hit && (ent_t == t_q);
		s_same  = s_hit && !s_exact && (prev_t_q == ent_t);
		st.scan_done   = eval && (s_err || s_exact || s_same);
		st.scan_interp = eval && s_hit && !s_exact && !s_same;
		st.div_done    = cmd.div && (dcnt_q == DLAST);
		st.out_free    = !out_valid_q || out_ready;
	end

	// product of magnitudes, sign kept apart
	always_comb begin
		logic signed [PW:0] dp;
		logic [PW:0]        mdp;
		logic [TW-1:0]      mdt;
		logic [63:0]        pp;
		mdt = t_q - prev_t_q;
		for (int i = 0; i < LANES; i++) begin
			dp       = {cur_p_q[i][PW-1], cur_p_q[i]} - {prev_p_q[i][PW-1], prev_p_q[i]};
			neg_d[i] = dp[PW];
			mdp      = dp[PW] ? (PW+1)'(-dp) : dp;
			pp       = mdp[PW-1:0] * mdt;
			prod[i]  = {1'b0, pp} + (mdp[PW] ? {1'b0, mdt, 32'b0} : '0);
		end
	end

	// one restoring divide step per lane
	always_comb begin
		logic [TW:0] trial;
		for (int i = 0; i < LANES; i++) begin
			trial = {rem_q[i], dvd_q[i][QW-1]};
			if (trial >= {1'b0, span_q}) begin
				trial    = trial - {1'b0, span_q};
				dvd_d[i] = {dvd_q[i][QW-2:0], 1'b1};
			end else begin
				dvd_d[i] = {dvd_q[i][QW-2:0], 1'b0};
			end
			rem_d[i] = trial[TW-1:0];
		end
	end

	// clamp quotient, apply sign, saturate to 32 bits
	always_comb begin
		logic [QW-1:0]      qs;
		logic signed [35:0] r;
		for (int i = 0; i < LANES; i++) begin
			qs = (dvd_q[i] > QSAT) ? QSAT : dvd_q[i];
			r  = neg_q[i] ? (36'(prev_p_q[i]) - $signed({2'b0, qs[33:0]})) :
				(36'(prev_p_q[i]) + $signed({2'b0, qs[33:0]}));
			if (r > RMAX) begin
				sat_p[i] = RMAX[PW-1:0];
			end else if (r < RMIN) begin
				sat_p[i] = RMIN[PW-1:0];
			end else begin
				sat_p[i] = r[PW-1:0];
			end
		end
	end

	// ring pointers and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			newest_q <= '0;
			vld_q    <= '0;
			rv_s1    <= 1'b0;
			iss_q    <= '0;
			chk_q    <= '0;
			dcnt_q   <= '0;
		end else begin
			rv_s1 <= cmd.scan;
			if (we) begin
				vld_q[wp_q] <= 1'b1;
				newest_q    <= t_q;
				wp_q        <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.rd) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
			if (cmd.latch) begin
				iss_q <= '0;
				chk_q <= '0;
			end else if (cmd.scan) begin
				iss_q <= iss_q + 1'b1;
				if (eval) begin
					chk_q <= chk_q + 1'b1;
				end
			end
			if (cmd.mul) begin
				dcnt_q <= '0;
			end else if (cmd.div) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	// read side valid flag follows the ram read
	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[raddr];
	end

	// payload path
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			t_q       <= time_stamp;
			p_in_q[0] <= pos_x;
			p_in_q[1] <= pos_y;
			p_in_q[2] <= pos_z;
			res_st_q  <= ST_ARG;
			res_t_q   <= '0;
			for (int i = 0; i < LANES; i++) begin
				res_p_q[i] <= '0;
			end
		end
		if (cmd.wr && wr_ok) begin
			res_st_q <= ST_OK;
		end
		if (cmd.rdw) begin
			res_st_q <= ST_OK;
			res_t_q  <= ent_t;
			for (int i = 0; i < LANES; i++) begin
				res_p_q[i] <= ent_p[i];
			end
		end
		// scan walk: keep the entry before the one in hand
		if (eval) begin
			cur_t_q <= ent_t;
			for (int i = 0; i < LANES; i++) begin
				cur_p_q[i] <= ent_p[i];
			end
			if (!s_hit) begin
				prev_t_q <= ent_t;
				for (int i = 0; i < LANES; i++) begin
					prev_p_q[i] <= ent_p[i];
				end
			end
			if (s_exact) begin
				res_st_q <= ST_OK;
				res_t_q  <= t_q;
				for (int i = 0; i < LANES; i++) begin
					res_p_q[i] <= ent_p[i];
				end
			end else if (s_same) begin
				res_st_q <= ST_STATE;
			end
		end
		if (cmd.mul) begin
			span_q <= cur_t_q - prev_t_q;
			for (int i = 0; i < LANES; i++) begin
				dvd_q[i] <= prod[i];
				rem_q[i] <= '0;
				neg_q[i] <= neg_d[i];
			end
		end
		if (cmd.div) begin
			for (int i = 0; i < LANES; i++) begin
				dvd_q[i] <= dvd_d[i];
				rem_q[i] <= rem_d[i];
			end
		end
		if (cmd.acc) begin
			res_st_q <= ST_OK;
			res_t_q  <= t_q;
			for (int i = 0; i < LANES; i++) begin
				res_p_q[i] <= sat_p[i];
			end
		end
		if (cmd.fin) begin
			status   <= res_st_q;
			out_time <= res_t_q;
			out_x    <= res_p_q[0];
			out_y    <= res_p_q[1];
			out_z    <= res_p_q[2];
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/timestamped_sample_ring_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_ring_interpolator_unit
// Time-stamped x,y,z sample ring with exact lookup and linear interpolation
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    func, time_stamp, pos_x/y/z
// out      source     out_valid / out_ready  status, out_time, out_x/y/z
//
// write steps through S_WR and S_FIN, unused codes go straight to S_FIN, read next
// through S_RD, S_RDW and S_FIN; a query walks the ring one entry a cycle from the
// oldest up to the hit, then for an interpolation takes a multiply step, one
// divide step per quotient bit and the accumulate and finish steps
// the divider takes one quotient bit a cycle, three lanes in parallel
// reset clears pointers and the per-entry valid bits at once, no clear pass
// a result held by out_ready low stalls the next beat only at its final step
// ----------------------------------------------------------------------------
module timestamped_sample_ring_interpolator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [31:0]        time_stamp,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        out_time,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	import trsi_pkg::*;

	cmd_t cmd;
	sts_t st;

	// sequencer
	trsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	trsi_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.time_stamp (time_stamp),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_time   (out_time),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z)
	);

	// a new beat always starts a busy period
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while still busy");

	// the output register is loaded only when it is free
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> st.out_free)
		else $error("result overwrote a pending beat");

	// the last divide step is followed by the accumulate step
	a_div_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |=> cmd.acc)
		else $error("divide finished without accumulate");

	// scan never reports both outcomes
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		st.scan_done |-> !st.scan_interp)
		else $error("scan gave conflicting outcomes");

endmodule
